// ===== hw/rtl/bsfc_pkg.sv =====
`default_nettype none

package bsfc_pkg;

    localparam logic [7:0] OPEN_BYTE = 8'd0;
    localparam logic [7:0] END_BYTE  = 8'd192;
    localparam logic [7:0] ESC_BYTE  = 8'd219;
    localparam logic [7:0] ESC_ZERO  = 8'd1;
    localparam logic [7:0] ESC_END   = 8'd193;
    localparam logic [7:0] ESC_ESC   = 8'd220;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Most results one input item can cause: opening, two escape bytes, closing.
    localparam int MAX_RES = 4;
    localparam int RES_IDX_W = $clog2(MAX_RES);
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
    } t_res;

    // One classified item: its results in order, and how many are used.
    typedef struct packed {
        t_res [MAX_RES-1:0]   res;
        logic [RES_CNT_W-1:0] count;
    } t_cmd;

    // Status of the command queue as seen by its neighbors.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

// ===== hw/rtl/bsfc_front.sv =====
`default_nettype none

module bsfc_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic              i_cfg_wr_data,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_last_of_packet,
    output      logic              o_cmd_push,
    output      bsfc_pkg::t_cmd    o_cmd
);

    logic r_mode;
    logic r_in_frame;
    logic r_esc_pending;
    logic n_in_frame;
    logic n_esc_pending;

    always_comb begin
        logic [bsfc_pkg::RES_CNT_W-1:0] cnt;
        bsfc_pkg::t_cmd                 cmd;
        cnt           = '0;
        cmd           = '0;
        n_in_frame    = r_in_frame;
        n_esc_pending = r_esc_pending;

        if (r_mode == bsfc_pkg::MODE_ENCODE) begin
            if (!r_in_frame) begin
                cmd.res[cnt[bsfc_pkg::RES_IDX_W-1:0]] = '{bsfc_pkg::OPEN_BYTE, bsfc_pkg::KIND_DATA};
                cnt        = cnt + 1'b1;
                n_in_frame = 1'b1;
            end
            if (i_data_byte == bsfc_pkg::OPEN_BYTE || i_data_byte == bsfc_pkg::END_BYTE ||
                i_data_byte == bsfc_pkg::ESC_BYTE) begin
                cmd.res[cnt[bsfc_pkg::RES_IDX_W-1:0]] = '{bsfc_pkg::ESC_BYTE, bsfc_pkg::KIND_DATA};
                cnt = cnt + 1'b1;
                if (i_data_byte == bsfc_pkg::OPEN_BYTE) begin
                    cmd.res[cnt[bsfc_pkg::RES_IDX_W-1:0]] =
                        '{bsfc_pkg::ESC_ZERO, bsfc_pkg::KIND_DATA};
                end else if (i_data_byte == bsfc_pkg::END_BYTE) begin
                    cmd.res[cnt[bsfc_pkg::RES_IDX_W-1:0]] =
                        '{bsfc_pkg::ESC_END, bsfc_pkg::KIND_DATA};
                end else begin
                    cmd.res[cnt[bsfc_pkg::RES_IDX_W-1:0]] =
                        '{bsfc_pkg::ESC_ESC, bsfc_pkg::KIND_DATA};
                end
                cnt = cnt + 1'b1;
            end else begin
                cmd.res[cnt[bsfc_pkg::RES_IDX_W-1:0]] = '{i_data_byte, bsfc_pkg::KIND_DATA};
                cnt = cnt + 1'b1;
            end
            if (i_last_of_packet) begin
                cmd.res[cnt[bsfc_pkg::RES_IDX_W-1:0]] = '{bsfc_pkg::END_BYTE, bsfc_pkg::KIND_DATA};
                cnt        = cnt + 1'b1;
                n_in_frame = 1'b0;
            end
        end else begin
            if (!r_in_frame) begin
                if (i_data_byte == bsfc_pkg::OPEN_BYTE) begin
                    n_in_frame    = 1'b1;
                    n_esc_pending = 1'b0;
                end else begin
                    cmd.res[0] = '{8'd0, bsfc_pkg::KIND_ERR};
                    cnt        = cnt + 1'b1;
                end
            end else if (r_esc_pending) begin
                cmd.res[0]    = '{i_data_byte - 8'd1, bsfc_pkg::KIND_DATA};
                cnt           = cnt + 1'b1;
                n_esc_pending = 1'b0;
            end else if (i_data_byte == bsfc_pkg::ESC_BYTE) begin
                n_esc_pending = 1'b1;
            end else if (i_data_byte == bsfc_pkg::END_BYTE) begin
                cmd.res[0] = '{8'd0, bsfc_pkg::KIND_END};
                cnt        = cnt + 1'b1;
                n_in_frame = 1'b0;
            end else if (i_data_byte == bsfc_pkg::OPEN_BYTE) begin
                // stray zero: report it and take it as a fresh opening
                cmd.res[0] = '{8'd0, bsfc_pkg::KIND_ERR};
                cnt        = cnt + 1'b1;
            end else begin
                cmd.res[0] = '{i_data_byte, bsfc_pkg::KIND_DATA};
                cnt        = cnt + 1'b1;
            end
        end

        cmd.count  = cnt;
        o_cmd      = cmd;
        o_cmd_push = i_accept && (cnt != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= bsfc_pkg::MODE_ENCODE;
            r_in_frame    <= 1'b0;
            r_esc_pending <= 1'b0;
        end else if (i_cfg_wr_en) begin
            // drop any partial frame
            r_mode        <= i_cfg_wr_data;
            r_in_frame    <= 1'b0;
            r_esc_pending <= 1'b0;
        end else if (i_accept) begin
            r_in_frame    <= n_in_frame;
            r_esc_pending <= n_esc_pending;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bsfc_queue.sv =====
`default_nettype none

module bsfc_queue #(
    parameter int DEPTH = bsfc_pkg::QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire bsfc_pkg::t_cmd    i_cmd,
    input  wire logic              i_pop,
    output      bsfc_pkg::t_cmd    o_cmd,
    output      bsfc_pkg::t_q_status o_status
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    bsfc_pkg::t_cmd r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    assign o_cmd          = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == FullCnt);
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bsfc_back.sv =====
`default_nettype none

module bsfc_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bsfc_pkg::t_cmd    i_cmd,
    input  wire bsfc_pkg::t_q_status i_q_status,
    output      logic              o_cmd_pop,
    input  wire logic              i_out_pop,
    output      logic              o_out_valid,
    output      logic [7:0]        o_out_byte,
    output      bsfc_pkg::t_kind   o_out_kind,
    output      logic              o_out_last
);

    bsfc_pkg::t_cmd                 r_cmd;
    logic [bsfc_pkg::RES_IDX_W-1:0] r_idx;
    logic                           r_busy;
    logic                           r_out_valid;
    logic [7:0]                     r_out_byte;
    bsfc_pkg::t_kind                r_out_kind;
    logic                           r_out_last;

    bsfc_pkg::t_cmd                 src;
    logic [bsfc_pkg::RES_IDX_W-1:0] idx;
    logic [bsfc_pkg::RES_CNT_W-1:0] n_pos;
    logic                           emit;
    logic                           done;

    // work from the held command, or straight from the queue head
    assign src       = r_busy ? r_cmd : i_cmd;
    assign idx       = r_busy ? r_idx : '0;
    assign emit      = (!r_out_valid || i_out_pop) && (r_busy || !i_q_status.empty);
    assign o_cmd_pop = emit && !r_busy;
    assign n_pos     = bsfc_pkg::RES_CNT_W'(idx) + 1'b1;
    assign done      = (n_pos == src.count);

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= src.res[idx].data;
            r_out_kind <= src.res[idx].kind;
            r_out_last <= done;
            r_cmd      <= src;
            r_idx      <= n_pos[bsfc_pkg::RES_IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_busy      <= !done;
                r_out_valid <= 1'b1;
            end else if (i_out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_kind  = r_out_kind;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

// ===== hw/rtl/byte_stuffing_frame_codec.sv =====
// Byte-stuffing frame codec with a one-bit mode register.
// Input side is a queue: offer a byte on i_data_byte/i_last_of_packet with push;
// it is taken on a clock edge where push is high and full is low.
// Result side is a queue: while empty is low, o_out_byte/o_kind/o_last show the
// oldest result; pop on a clock edge where empty is low takes it.
// Mode 0 encodes packets into frames (up to four results per byte), mode 1
// decodes frames (zero or one result per byte). Writing the mode abandons any
// partial frame; write only while the block is idle.
// The front classifies a byte in the cycle it is taken and queues its results
// in a command queue of QUEUE_DEPTH entries; the back sends one result per
// cycle through an output register while the receiver pops. The first result
// of a byte passes through the command queue and then the output register.
// Sustained input rate is one byte per cycle while each byte yields at most
// one result and results are popped; a byte with more holds the back until all
// are sent, so the result port, one beat per cycle, sets throughput.
// When the receiver stalls, the output register holds, the queue fills and
// full rises; no result is lost. Reset clears the mode to encode, leaves the
// codec outside a frame and empties the queue.
`default_nettype none

module byte_stuffing_frame_codec #(
    parameter int QUEUE_DEPTH = bsfc_pkg::QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic       i_cfg_wr_data,
    input  wire logic       push,
    output      logic       full,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_of_packet,
    output      logic       empty,
    input  wire logic       pop,
    output      logic [7:0] o_out_byte,
    output      logic [1:0] o_kind,
    output      logic       o_last
);

    bsfc_pkg::t_cmd      front_cmd;
    bsfc_pkg::t_cmd      head_cmd;
    bsfc_pkg::t_q_status q_status;
    bsfc_pkg::t_kind     out_kind;
    logic                cmd_push;
    logic                cmd_pop;
    logic                accept;
    logic                out_valid;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;
    assign empty  = !out_valid;
    assign o_kind = out_kind;

    bsfc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_accept         (accept),
        .i_data_byte      (i_data_byte),
        .i_last_of_packet (i_last_of_packet),
        .o_cmd_push       (cmd_push),
        .o_cmd            (front_cmd)
    );

    bsfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (cmd_push),
        .i_cmd    (front_cmd),
        .i_pop    (cmd_pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    bsfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_q_status  (q_status),
        .o_cmd_pop   (cmd_pop),
        .i_out_pop   (pop),
        .o_out_valid (out_valid),
        .o_out_byte  (o_out_byte),
        .o_out_kind  (out_kind),
        .o_out_last  (o_last)
    );

`ifndef ASSERT_OFF
    a_marker_result_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && out_kind != bsfc_pkg::KIND_DATA) |-> (o_out_byte == 8'd0 && o_last))
        else $error("end or error result without zero byte or last flag");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |-> !q_status.full)
        else $error("command queue written while full");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !q_status.empty)
        else $error("command queue read while empty");

    a_queued_cmd_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |-> (front_cmd.count != '0))
        else $error("command without results queued");
`endif

endmodule

`default_nettype wire
